/* design/grid_wall_follower_assert.svh */
// Assertion macros used by the checker of the grid wall follower.
// Each macro expands to one labelled concurrent assertion, clocked on the
// rising edge and disabled while reset is held.
`ifndef GRID_WALL_FOLLOWER_ASSERT_SVH
`define GRID_WALL_FOLLOWER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GWF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/gwf_pkg.sv */
// ----------------------------------------------------------------------------
// Grid wall follower package
// Grid geometry, command and status codes, transaction types and the
// neighbour arithmetic shared by the controller, datapath and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package gwf_pkg;

	localparam int GRID_ROWS = 16;
	localparam int GRID_COLS = 16;
	localparam int CELLS     = GRID_ROWS * GRID_COLS;
	localparam int ADDR_W    = $clog2(CELLS);

	localparam int COORD_W   = 4;
	localparam int COORD_MAX = (1 << COORD_W) - 1;
	// coordinate plus room for a step below zero or past the top
	localparam int NB_W      = COORD_W + 2;

	localparam int TRIES     = 4;
	localparam int KW        = $clog2(TRIES);
	localparam int TRY_W     = $clog2(TRIES + 1);

	typedef logic [1:0]         cmd_t;
	typedef logic [1:0]         dir_t;
	typedef logic [1:0]         status_t;
	typedef logic [COORD_W-1:0] coord_t;

	localparam cmd_t CMD_LOAD  = 2'd0;
	localparam cmd_t CMD_START = 2'd1;
	localparam cmd_t CMD_STEP  = 2'd2;

	localparam dir_t DIR_RIGHT = 2'd0;
	localparam dir_t DIR_DOWN  = 2'd1;
	localparam dir_t DIR_LEFT  = 2'd2;
	localparam dir_t DIR_UP    = 2'd3;

	localparam status_t ST_ACCEPTED = 2'd0;
	localparam status_t ST_MOVED    = 2'd1;
	localparam status_t ST_ESCAPED  = 2'd2;
	localparam status_t ST_STUCK    = 2'd3;

	// try order relative to heading: right turn, ahead, left turn, back
	localparam dir_t TURN_RIGHT = 2'd1;
	localparam dir_t TURN_AHEAD = 2'd0;
	localparam dir_t TURN_LEFT  = 2'd3;
	localparam dir_t TURN_BACK  = 2'd2;

	typedef struct packed {
		cmd_t   cmd;
		coord_t row;
		coord_t col;
		logic   open;
		dir_t   heading;
	} req_t;

	typedef struct packed {
		coord_t  pos_row;
		coord_t  pos_col;
		dir_t    pos_heading;
		status_t status;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic          take;
		logic          issue;
		logic [KW-1:0] try_idx;
		logic          check;
		logic          last;
		logic          finish;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic walk;
		logic hit;
	} sts_t;

	typedef struct packed {
		logic   inb;
		coord_t r;
		coord_t c;
		dir_t   dir;
	} cand_t;

	function automatic dir_t try_dir(dir_t hd, logic [KW-1:0] k);
		dir_t turn;
		case (k)
			2'd0:    turn = TURN_RIGHT;
			2'd1:    turn = TURN_AHEAD;
			2'd2:    turn = TURN_LEFT;
			default: turn = TURN_BACK;
		endcase
		return hd + turn;
	endfunction

	function automatic logic in_grid(logic [NB_W-1:0] r, logic [NB_W-1:0] c);
		return (int'(r) <= COORD_MAX) && (int'(c) <= COORD_MAX) &&
			(int'(r) < GRID_ROWS) && (int'(c) < GRID_COLS);
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(coord_t r, coord_t c);
		return ADDR_W'(int'(r) * GRID_COLS + int'(c));
	endfunction

	// neighbour one cell away; a step below zero wraps high and falls outside
	function automatic cand_t step_to(coord_t r, coord_t c, dir_t d);
		logic [NB_W-1:0] nr;
		logic [NB_W-1:0] nc;
		cand_t           res;
		nr = {2'b00, r};
		nc = {2'b00, c};
		case (d)
			DIR_RIGHT: nc = nc + 1'b1;
			DIR_DOWN:  nr = nr + 1'b1;
			DIR_LEFT:  nc = nc - 1'b1;
			default:   nr = nr - 1'b1;
		endcase
		res.inb = in_grid(nr, nc);
		res.r   = nr[COORD_W-1:0];
		res.c   = nc[COORD_W-1:0];
		res.dir = d;
		return res;
	endfunction

endpackage

`default_nettype wire

/* design/gwf_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gwf_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

/* design/gwf_ctrl.sv */
// ----------------------------------------------------------------------------
// Grid wall follower controller
// Sequences item intake, the neighbour probe and the result handover.
// ----------------------------------------------------------------------------
`default_nettype none

module gwf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	input  gwf_pkg::sts_t sts,
	output gwf_pkg::ctl_t ctl
);

	import gwf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_PROBE  = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t           state_q, state_d;
	logic [TRY_W-1:0] n_q, n_d;
	logic             rsp_valid_q, rsp_valid_d;
	logic             room;

	assign room      = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d     = state_q;
		n_d         = n_q;
		rsp_valid_d = rsp_valid_q && rsp_stall;
		ctl         = '0;
		ctl.try_idx = n_q[KW-1:0];
		unique case (state_q)
			S_IDLE: begin
				ctl.take = req_valid;
				if (req_valid) begin
					n_d     = '0;
					state_d = sts.walk ? S_PROBE : S_FINISH;
				end
			end
			S_PROBE: begin
				// issue one read a cycle, check the read issued just before it
				ctl.issue = (n_q != TRY_W'(TRIES));
				ctl.check = (n_q != '0);
				ctl.last  = (n_q == TRY_W'(TRIES));
				if (ctl.issue) begin
					n_d = n_q + 1'b1;
				end
				if (ctl.check && (sts.hit || ctl.last)) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (room) begin
					ctl.finish  = 1'b1;
					rsp_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			n_q         <= n_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

endmodule

`default_nettype wire

/* design/gwf_dp.sv */
// ----------------------------------------------------------------------------
// Grid wall follower datapath
// Cell map, walker position and heading, neighbour probe and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gwf_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  gwf_pkg::req_t req,
	input  gwf_pkg::ctl_t ctl,
	output gwf_pkg::sts_t sts,
	output gwf_pkg::rsp_t rsp
);

	import gwf_pkg::*;

	coord_t            row_q, col_q;
	dir_t              hd_q;
	status_t           status_q;
	logic [CELLS-1:0]  written_q;
	cand_t             cand_s1, nb;
	logic              written_s1;
	logic              rdata;
	logic              at_last;
	logic              load_we;
	logic [ADDR_W-1:0] waddr, paddr, addr;
	rsp_t              rsp_q;

	assign at_last = (int'(col_q) == GRID_COLS - 1);
	assign load_we = ctl.take && (req.cmd == CMD_LOAD) &&
		in_grid({2'b00, req.row}, {2'b00, req.col});
	assign waddr   = cell_addr(req.row, req.col);
	assign nb      = step_to(row_q, col_q, try_dir(hd_q, ctl.try_idx));
	assign paddr   = cell_addr(nb.r, nb.c);
	assign addr    = load_we ? waddr : paddr;

	assign sts.walk = (req.cmd == CMD_STEP) && !at_last;
	assign sts.hit  = cand_s1.inb && written_s1 && rdata;
	assign rsp      = rsp_q;

	gwf_ram #(
		.WIDTH(1),
		.DEPTH(CELLS)
	) u_map (
		.clk  (clk),
		.we   (load_we),
		.addr (addr),
		.wdata(req.open),
		.rdata(rdata)
	);

	// a cell never written reads as blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (load_we) begin
			written_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			hd_q  <= DIR_RIGHT;
		end else if (ctl.take && (req.cmd == CMD_START)) begin
			row_q <= req.row;
			col_q <= req.col;
			hd_q  <= req.heading;
		end else if (ctl.check && sts.hit) begin
			row_q <= cand_s1.r;
			col_q <= cand_s1.c;
			hd_q  <= cand_s1.dir;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			status_q <= ((req.cmd == CMD_STEP) && at_last) ? ST_ESCAPED : ST_ACCEPTED;
		end else if (ctl.check && sts.hit) begin
			status_q <= (int'(cand_s1.c) == GRID_COLS - 1) ? ST_ESCAPED : ST_MOVED;
		end else if (ctl.check && ctl.last) begin
			status_q <= ST_STUCK;
		end
		if (ctl.issue) begin
			cand_s1    <= nb;
			written_s1 <= written_q[paddr];
		end
		if (ctl.finish) begin
			rsp_q <= '{pos_row: row_q, pos_col: col_q, pos_heading: hd_q, status: status_q};
		end
	end

endmodule

`default_nettype wire

/* design/grid_wall_follower.sv */
// ----------------------------------------------------------------------------
// Grid wall follower
// Right-hand wall follower on a map of open and blocked cells: load a cell,
// set the start, or take one step trying right, ahead, left, then back.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall  gwf_pkg::req_t
//   rsp      out        rsp_valid/rsp_stall  gwf_pkg::rsp_t
//
// Load, start and unused commands go from acceptance straight to the finish state.
// A step does the same when already on the last column; otherwise the single-port
// map memory gives one neighbour read a cycle, each checked once registered, for up to four tries.
// Reset marks every cell blocked through one flag per cell; no clearing pass.
// One item is in work at a time; its result waits in the output register
// while the next item is taken, and a stall holds the result as it is.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_wall_follower (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  gwf_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output gwf_pkg::rsp_t rsp
);

	import gwf_pkg::*;

	ctl_t ctl;
	sts_t sts;

	gwf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	gwf_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.ctl   (ctl),
		.sts   (sts),
		.rsp   (rsp)
	);

endmodule

`default_nettype wire

/* design/grid_wall_follower_chk.sv */
// ----------------------------------------------------------------------------
// Grid wall follower checker
// Port-level checks on transaction order and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_wall_follower_assert.svh"

module grid_wall_follower_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input gwf_pkg::rsp_t rsp
);

	import gwf_pkg::*;

	`GWF_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")
	`GWF_ASSERT_NEXT(a_one_item, clk, arst_n, req_valid && !req_stall, req_stall, "second transaction taken while busy")
	`GWF_ASSERT_NOW(a_escape_col, clk, arst_n, rsp_valid && (rsp.status == ST_ESCAPED), int'(rsp.pos_col) == GRID_COLS - 1, "escaped away from last column")
	`GWF_ASSERT_NOW(a_moved_col, clk, arst_n, rsp_valid && (rsp.status == ST_MOVED), int'(rsp.pos_col) != GRID_COLS - 1, "move onto last column not flagged escaped")

endmodule

bind grid_wall_follower grid_wall_follower_chk u_chk (.*);

`default_nettype wire
